/* design/mbps_pkg.sv */
// Package for the masked byte pattern search block.
// Holds the register map codes, register reset values and fixed field widths.
// No dependencies.
`default_nettype none

package mbps_pkg;

    // register map, one 64-bit register per 8-byte slot
    typedef enum logic [2:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_COMPARE_EN   = 3'd2,
        REG_PATTERN_LEN  = 3'd3,
        REG_MATCH_LIMIT  = 3'd4
    } reg_index_t;

    localparam int unsigned PADDR_BITS    = 6;
    localparam int unsigned PDATA_BITS    = 64;
    localparam int unsigned PATTERN_BYTES = 16;
    localparam int unsigned PLEN_BITS     = 5;
    localparam int unsigned LIMIT_BITS    = 23;
    localparam int unsigned OUT_ADDR_BITS = 48;

    localparam logic [LIMIT_BITS-1:0]    LIMIT_CEILING = 23'd8000000;
    localparam logic [LIMIT_BITS-1:0]    LIMIT_RESET   = 23'd1000000;
    localparam logic [PATTERN_BYTES-1:0] ENABLE_RESET  = 16'hFFFF;
    localparam logic [PLEN_BITS-1:0]     PLEN_RESET    = 5'd1;

endpackage

`default_nettype wire

/* design/masked_byte_pattern_search_top.sv */
// Masked byte pattern search, top level: sliding window, masked compare,
// match counting with limit, APB register file. Uses mbps_pkg.
`default_nettype none

// channel   | handshake                | payload
// ----------+--------------------------+----------------------------------------
// in        | in_valid / in_ready      | data_byte, byte_address, run_start,
//           |                          | search_start
// out       | out_valid / out_ready    | match_address, first_byte, limit_reached
// config    | psel/penable/pwrite      | paddr, pwdata, prdata (pready tied high)
//
// One byte per cycle: a beat is compared against the whole window in the cycle it
// is accepted and its result, if any, sits in the output register the next cycle.
// in_ready is high whenever the output register is empty or being drained, so
// a stalled result holds only the input side, for as long as out_ready stays low.
// rst_n clears the window, run fill, match count, stop flag; resets the registers.
module masked_byte_pattern_search_top #(
    parameter int unsigned MAX_PATTERN_BYTES = 16,
    parameter int unsigned ADDRESS_BITS      = 48,
    parameter int unsigned COUNT_BITS        = 23
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // input beats
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [7:0]                           data_byte,
    input  wire logic [ADDRESS_BITS-1:0]              byte_address,
    input  wire logic                                 run_start,
    input  wire logic                                 search_start,
    // result beats
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [ADDRESS_BITS-1:0]                   match_address,
    output logic [7:0]                                first_byte,
    output logic                                      limit_reached,
    // configuration
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [mbps_pkg::PADDR_BITS-1:0]      paddr,
    input  wire logic [mbps_pkg::PDATA_BITS-1:0]      pwdata,
    output logic [mbps_pkg::PDATA_BITS-1:0]           prdata,
    output logic                                      pready
);

    localparam int unsigned FILL_W = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int unsigned IDX_W  = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam int unsigned NCMP   = (MAX_PATTERN_BYTES < mbps_pkg::PATTERN_BYTES)
                                     ? MAX_PATTERN_BYTES : mbps_pkg::PATTERN_BYTES;
    localparam int unsigned CMP_W  = (COUNT_BITS > mbps_pkg::LIMIT_BITS)
                                     ? COUNT_BITS : mbps_pkg::LIMIT_BITS;
    localparam int unsigned ADDR_CUT = (ADDRESS_BITS > mbps_pkg::OUT_ADDR_BITS)
                                       ? ADDRESS_BITS - mbps_pkg::OUT_ADDR_BITS : 0;
    localparam logic [ADDRESS_BITS-1:0] ADDR_MASK = {ADDRESS_BITS{1'b1}} >> ADDR_CUT;

    // configuration registers
    logic [63:0]                              pattern_low_reg;
    logic [63:0]                              pattern_high_reg;
    logic [mbps_pkg::PATTERN_BYTES-1:0]       compare_en_reg;
    logic [mbps_pkg::PLEN_BITS-1:0]           pattern_len_reg;
    logic [mbps_pkg::LIMIT_BITS-1:0]          match_limit_reg;

    // search state
    logic [7:0]                               window_reg [MAX_PATTERN_BYTES];
    logic [7:0]                               window_next [MAX_PATTERN_BYTES];
    logic [FILL_W-1:0]                        run_fill_reg;
    logic [FILL_W-1:0]                        run_fill_next;
    logic [COUNT_BITS-1:0]                    match_count_reg;
    logic [COUNT_BITS-1:0]                    match_count_next;
    logic                                     stopped_reg;
    logic                                     stopped_next;

    // output register
    logic                                     out_valid_reg;
    logic                                     out_valid_next;
    logic [ADDRESS_BITS-1:0]                  match_address_reg;
    logic [ADDRESS_BITS-1:0]                  match_address_next;
    logic [7:0]                               first_byte_reg;
    logic                                     limit_reached_reg;

    logic                                     in_fire;
    logic                                     cfg_write;
    mbps_pkg::reg_index_t                     cfg_index;
    logic [127:0]                             pattern_all;
    logic [6:0]                               plen_raw;
    logic [FILL_W-1:0]                        plen;
    logic [IDX_W-1:0]                         plen_m1;
    logic [mbps_pkg::LIMIT_BITS-1:0]          limit_used;
    logic [FILL_W-1:0]                        fill_base;
    logic [COUNT_BITS-1:0]                    count_base;
    logic [COUNT_BITS-1:0]                    count_inc;
    logic                                     stopped_base;
    logic                                     bytes_match;
    logic                                     hit;
    logic                                     reached;

    assign in_ready    = !out_valid_reg || out_ready;
    assign in_fire     = in_valid && in_ready;
    assign pready      = 1'b1;
    assign cfg_write   = psel && penable && pwrite && pready;
    assign cfg_index   = mbps_pkg::reg_index_t'(paddr[5:3]);
    assign pattern_all = {pattern_high_reg, pattern_low_reg};

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            compare_en_reg   <= mbps_pkg::ENABLE_RESET;
            pattern_len_reg  <= mbps_pkg::PLEN_RESET;
            match_limit_reg  <= mbps_pkg::LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mbps_pkg::REG_PATTERN_LOW:  pattern_low_reg  <= pwdata;
                mbps_pkg::REG_PATTERN_HIGH: pattern_high_reg <= pwdata;
                mbps_pkg::REG_COMPARE_EN:
                    compare_en_reg  <= pwdata[mbps_pkg::PATTERN_BYTES-1:0];
                mbps_pkg::REG_PATTERN_LEN:
                    pattern_len_reg <= pwdata[mbps_pkg::PLEN_BITS-1:0];
                mbps_pkg::REG_MATCH_LIMIT:
                    match_limit_reg <= pwdata[mbps_pkg::LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        case (cfg_index)
            mbps_pkg::REG_PATTERN_LOW:  prdata = pattern_low_reg;
            mbps_pkg::REG_PATTERN_HIGH: prdata = pattern_high_reg;
            mbps_pkg::REG_COMPARE_EN:
                prdata = {{(64 - mbps_pkg::PATTERN_BYTES){1'b0}}, compare_en_reg};
            mbps_pkg::REG_PATTERN_LEN:
                prdata = {{(64 - mbps_pkg::PLEN_BITS){1'b0}}, pattern_len_reg};
            mbps_pkg::REG_MATCH_LIMIT:
                prdata = {{(64 - mbps_pkg::LIMIT_BITS){1'b0}}, match_limit_reg};
            default: prdata = '0;
        endcase
    end

    // effective pattern length and limit
    always_comb
    begin
        plen_raw = {2'b00, pattern_len_reg};
        if (plen_raw == 7'd0)
            plen = FILL_W'(1);
        else if (plen_raw > 7'(MAX_PATTERN_BYTES))
            plen = FILL_W'(MAX_PATTERN_BYTES);
        else
            plen = FILL_W'(plen_raw);
        plen_m1 = IDX_W'(plen - FILL_W'(1));

        if (match_limit_reg == '0 || match_limit_reg > mbps_pkg::LIMIT_CEILING)
            limit_used = mbps_pkg::LIMIT_CEILING;
        else
            limit_used = match_limit_reg;
    end

    // window shift, newest byte at position zero
    always_comb
    begin
        window_next[0] = data_byte;
        for (int i = 1; i < MAX_PATTERN_BYTES; i++)
        begin
            window_next[i] = window_reg[i-1];
        end
    end

    // run and search bookkeeping for this beat
    always_comb
    begin
        fill_base    = (run_start || search_start) ? '0 : run_fill_reg;
        count_base   = search_start ? '0 : match_count_reg;
        stopped_base = search_start ? 1'b0 : stopped_reg;
        if (fill_base < FILL_W'(MAX_PATTERN_BYTES))
            run_fill_next = fill_base + FILL_W'(1);
        else
            run_fill_next = fill_base;
        count_inc = count_base + COUNT_BITS'(1);
        reached   = CMP_W'(count_inc) >= CMP_W'(limit_used);
    end

    // masked compare of all window positions within the pattern length, in parallel
    always_comb
    begin
        bytes_match = 1'b1;
        for (int k = 0; k < NCMP; k++)
        begin
            if (FILL_W'(k) < plen && compare_en_reg[k] &&
                pattern_all[8*k +: 8] != window_next[plen_m1 - IDX_W'(k)])
            begin
                bytes_match = 1'b0;
            end
        end
        hit = bytes_match && !stopped_base && run_fill_next >= plen;
    end

    // next state of counters and result
    always_comb
    begin
        match_count_next   = hit ? count_inc : count_base;
        stopped_next       = stopped_base || (hit && reached);
        match_address_next = (byte_address - ADDRESS_BITS'(plen_m1)) & ADDR_MASK;
        if (in_fire)
            out_valid_next = hit;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // search state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PATTERN_BYTES; i++)
            begin
                window_reg[i] <= '0;
            end
            run_fill_reg    <= '0;
            match_count_reg <= '0;
            stopped_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                for (int i = 0; i < MAX_PATTERN_BYTES; i++)
                begin
                    window_reg[i] <= window_next[i];
                end
                run_fill_reg    <= run_fill_next;
                match_count_reg <= match_count_next;
                stopped_reg     <= stopped_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_fire && hit)
        begin
            match_address_reg <= match_address_next;
            first_byte_reg    <= window_next[plen_m1];
            limit_reached_reg <= reached;
        end
    end

    assign out_valid     = out_valid_reg;
    assign match_address = match_address_reg;
    assign first_byte    = first_byte_reg;
    assign limit_reached = limit_reached_reg;

endmodule

`default_nettype wire

/* design/mbps_checker.sv */
// Port-level checker for the masked byte pattern search top level.
// Watches only the top-level ports; bound to masked_byte_pattern_search_top.
`default_nettype none

module mbps_checker #(
    parameter int unsigned ADDRESS_BITS = 48
) (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_ready,
    input wire logic                    search_start,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic [ADDRESS_BITS-1:0] match_address,
    input wire logic [7:0]              first_byte,
    input wire logic                    limit_reached
);

    logic in_fire;
    logic out_fire;
    logic stopped_reg;
    logic stopped_next;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // search is stopped once the limit beat has gone out, until a new search
    always_comb
    begin
        if (in_fire && search_start)
            stopped_next = 1'b0;
        else if (out_fire && limit_reached)
            stopped_next = 1'b1;
        else
            stopped_next = stopped_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stopped_reg <= 1'b0;
        else
            stopped_reg <= stopped_next;
    end

    // a stalled result beat holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(match_address) &&
            $stable(first_byte) && $stable(limit_reached))
        else $error("result beat changed while stalled");

    // an empty output register never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output register");

    // no result appears without an input beat the cycle before
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire && (!out_valid || out_ready) |=> !out_valid)
        else $error("result beat without input beat");

    // after the limit beat no result until a new search starts
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !search_start && (stopped_reg || (out_fire && limit_reached))
            |=> !out_valid)
        else $error("result after match limit");

endmodule

bind masked_byte_pattern_search_top mbps_checker #(
    .ADDRESS_BITS (ADDRESS_BITS)
) u_mbps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .search_start  (search_start),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .match_address (match_address),
    .first_byte    (first_byte),
    .limit_reached (limit_reached)
);

`default_nettype wire

/* tb/sv/masked_byte_pattern_search_top_test.sv */
`timescale 1ns / 1ps
// Testbench for masked_byte_pattern_search_top: directed and random byte streams,
// a window predictor of its own and an in-order result checker.
// Depends on mbps_pkg and the masked_byte_pattern_search_top RTL.
module masked_byte_pattern_search_top_test;

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_BYTES     = 175;

    typedef struct packed {
        logic [mbps_pkg::OUT_ADDR_BITS-1:0] addr;
        logic [7:0]                         first;
        logic                               limit;
    } match_t;

    // dut signals
    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic [7:0]                         data_byte = '0;
    logic [mbps_pkg::OUT_ADDR_BITS-1:0] byte_address = '0;
    logic                               run_start = 1'b0;
    logic                               search_start = 1'b0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic [mbps_pkg::OUT_ADDR_BITS-1:0] match_address;
    logic [7:0]                         first_byte;
    logic                               limit_reached;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [mbps_pkg::PADDR_BITS-1:0]    paddr = '0;
    logic [mbps_pkg::PDATA_BITS-1:0]    pwdata = '0;
    logic [mbps_pkg::PDATA_BITS-1:0]    prdata;
    logic                               pready;

    // register shadow
    logic [63:0]                        pat_low = '0;
    logic [63:0]                        pat_high = '0;
    logic [mbps_pkg::PATTERN_BYTES-1:0] cmp_enable = mbps_pkg::ENABLE_RESET;
    logic [mbps_pkg::PLEN_BITS-1:0]     pat_len = mbps_pkg::PLEN_RESET;
    logic [mbps_pkg::LIMIT_BITS-1:0]    hit_limit = mbps_pkg::LIMIT_RESET;

    // predictor state
    logic [7:0]                         win_bytes [mbps_pkg::PATTERN_BYTES];
    int                                 run_len = 0;
    logic [mbps_pkg::LIMIT_BITS-1:0]    hit_count = '0;
    bit                                 search_halted = 1'b0;

    match_t                             expected_matches [$];
    match_t                             oldest_match;
    int                                 error_count = 0;
    int                                 idle_cycles = 0;
    bit                                 no_idle = 1'b0;
    int                                 ready_hold = 0;
    int                                 ready_gap = 0;

    masked_byte_pattern_search_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .byte_address  (byte_address),
        .run_start     (run_start),
        .search_start  (search_start),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .match_address (match_address),
        .first_byte    (first_byte),
        .limit_reached (limit_reached),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        foreach (win_bytes[i])
            win_bytes[i] = 8'h00;
    end

    function automatic logic [63:0] random64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [7:0] pattern_byte(input int k);
        return (k < 8) ? pat_low[8*k +: 8] : pat_high[8*(k-8) +: 8];
    endfunction

    // length in use: zero counts as one, long values saturate
    function automatic int active_length();
        if (pat_len == 0)
            return 1;
        if (int'(pat_len) > int'(mbps_pkg::PATTERN_BYTES))
            return mbps_pkg::PATTERN_BYTES;
        return int'(pat_len);
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // shift one byte into the window and work out the match it causes
    function automatic bit scan_byte(input logic [7:0] d,
                                     input logic [mbps_pkg::OUT_ADDR_BITS-1:0] a,
                                     input bit rs, input bit ss, output match_t m);
        int plen;
        int i;
        bit new_run;
        bit hit;
        logic [mbps_pkg::LIMIT_BITS-1:0] lim;
        plen = active_length();
        new_run = rs;
        m = '0;
        if (ss)
        begin
            hit_count = '0;
            search_halted = 1'b0;
            new_run = 1'b1;
        end
        if (new_run)
            run_len = 0;
        for (i = mbps_pkg::PATTERN_BYTES - 1; i > 0; i--)
            win_bytes[i] = win_bytes[i-1];
        win_bytes[0] = d;
        if (run_len < mbps_pkg::PATTERN_BYTES)
            run_len++;
        if (search_halted || run_len < plen)
            return 1'b0;
        hit = 1'b1;
        for (i = 0; i < plen; i++)
            if (cmp_enable[i] && pattern_byte(i) != win_bytes[plen-1-i])
                hit = 1'b0;
        if (!hit)
            return 1'b0;
        hit_count = hit_count + mbps_pkg::LIMIT_BITS'(1);
        lim = (hit_limit == 0 || hit_limit > mbps_pkg::LIMIT_CEILING)
              ? mbps_pkg::LIMIT_CEILING : hit_limit;
        m.addr = a - mbps_pkg::OUT_ADDR_BITS'(plen - 1);
        m.first = win_bytes[plen-1];
        m.limit = (hit_count >= lim);
        if (m.limit)
            search_halted = 1'b1;
        return 1'b1;
    endfunction

    // one apb transfer: setup, access, then idle
    task automatic apb_transfer(input bit wr, input mbps_pkg::reg_index_t idx,
                                input logic [63:0] wdata, output logic [63:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 3'b000};
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // read a register back and compare with the shadow
    task automatic check_reg(input mbps_pkg::reg_index_t idx);
        logic [63:0] expected_value;
        logic [63:0] read_value;
        case (idx)
            mbps_pkg::REG_PATTERN_LOW:  expected_value = pat_low;
            mbps_pkg::REG_PATTERN_HIGH: expected_value = pat_high;
            mbps_pkg::REG_COMPARE_EN:   expected_value = 64'(cmp_enable);
            mbps_pkg::REG_PATTERN_LEN:  expected_value = 64'(pat_len);
            mbps_pkg::REG_MATCH_LIMIT:  expected_value = 64'(hit_limit);
            default:                    expected_value = '0;
        endcase
        apb_transfer(1'b0, idx, '0, read_value);
        if (read_value !== expected_value)
        begin
            $display("%0t register %s read: expected %h actual %h",
                     $time, idx.name(), expected_value, read_value);
            error_count++;
        end
    endtask

    task automatic write_reg(input mbps_pkg::reg_index_t idx, input logic [63:0] value);
        logic [63:0] unused;
        apb_transfer(1'b1, idx, value, unused);
        case (idx)
            mbps_pkg::REG_PATTERN_LOW:  pat_low = value;
            mbps_pkg::REG_PATTERN_HIGH: pat_high = value;
            mbps_pkg::REG_COMPARE_EN:   cmp_enable = value[mbps_pkg::PATTERN_BYTES-1:0];
            mbps_pkg::REG_PATTERN_LEN:  pat_len = value[mbps_pkg::PLEN_BITS-1:0];
            mbps_pkg::REG_MATCH_LIMIT:  hit_limit = value[mbps_pkg::LIMIT_BITS-1:0];
            default:                    ;
        endcase
        check_reg(idx);
    endtask

    // drive one input beat, predict at acceptance, then maybe idle
    task automatic send_byte(input logic [7:0] d,
                             input logic [mbps_pkg::OUT_ADDR_BITS-1:0] a,
                             input bit rs, input bit ss);
        match_t m;
        int gap;
        in_valid <= 1'b1;
        data_byte <= d;
        byte_address <= a;
        run_start <= rs;
        search_start <= ss;
        do
            @(posedge clk);
        while (!in_ready);
        if (scan_byte(d, a, rs, ss, m))
            expected_matches.insert(expected_matches.size(), m);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending and let every expected result drain
    task automatic drain_matches();
        in_valid <= 1'b0;
        while (expected_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // reset register values, then the default one-byte zero pattern
    task automatic test_reset_defaults();
        check_reg(mbps_pkg::REG_PATTERN_LOW);
        check_reg(mbps_pkg::REG_PATTERN_HIGH);
        check_reg(mbps_pkg::REG_COMPARE_EN);
        check_reg(mbps_pkg::REG_PATTERN_LEN);
        check_reg(mbps_pkg::REG_MATCH_LIMIT);
        send_byte(8'h00, {mbps_pkg::OUT_ADDR_BITS{1'b1}}, 1'b1, 1'b1);
        send_byte(8'hFF, '0, 1'b0, 1'b0);
        drain_matches();
    endtask

    // full-length window with wildcard ends, start address wraps below zero
    task automatic test_masked_window();
        logic [mbps_pkg::OUT_ADDR_BITS-1:0] a;
        int k;
        write_reg(mbps_pkg::REG_PATTERN_LOW, random64());
        write_reg(mbps_pkg::REG_PATTERN_HIGH, random64());
        write_reg(mbps_pkg::REG_COMPARE_EN, 64'h7BDE);
        write_reg(mbps_pkg::REG_PATTERN_LEN, 64'(mbps_pkg::PATTERN_BYTES));
        a = {mbps_pkg::OUT_ADDR_BITS{1'b1}} - 48'd7;
        for (k = 0; k < mbps_pkg::PATTERN_BYTES; k++)
        begin
            send_byte(cmp_enable[k] ? pattern_byte(k) : ~pattern_byte(k), a, k == 0, 1'b0);
            a = a + mbps_pkg::OUT_ADDR_BITS'(1);
        end
        drain_matches();
    endtask

    // a window never spans a run break
    task automatic test_run_split();
        write_reg(mbps_pkg::REG_COMPARE_EN, 64'hFFFF);
        write_reg(mbps_pkg::REG_PATTERN_LEN, 64'd2);
        send_byte(pattern_byte(0), 48'h1000, 1'b1, 1'b0);
        send_byte(pattern_byte(1), 48'h1001, 1'b1, 1'b0);
        send_byte(pattern_byte(0), 48'h1002, 1'b0, 1'b0);
        send_byte(pattern_byte(1), 48'h1003, 1'b0, 1'b0);
        drain_matches();
    endtask

    // limit of one: flagged match, suppression, restart by a new search
    task automatic test_match_limit();
        write_reg(mbps_pkg::REG_PATTERN_LEN, 64'd1);
        write_reg(mbps_pkg::REG_COMPARE_EN, 64'h0001);
        write_reg(mbps_pkg::REG_MATCH_LIMIT, 64'd1);
        send_byte(pattern_byte(0), 48'h2000, 1'b0, 1'b1);
        send_byte(pattern_byte(0), 48'h2001, 1'b0, 1'b0);
        send_byte(pattern_byte(0), 48'h2002, 1'b0, 1'b1);
        drain_matches();
    endtask

    // random settings per phase, streams with planted patterns and noise
    task automatic test_random_stream();
        int phase;
        int n;
        int r;
        int r2;
        int plant_idx;
        int len;
        logic [15:0] en;
        logic [mbps_pkg::LIMIT_BITS-1:0] lim;
        logic [63:0] value;
        logic [7:0] d;
        logic [mbps_pkg::OUT_ADDR_BITS-1:0] a;
        bit rs;
        bit ss;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            // pick this phase's settings, extremes first
            case (phase)
                0:
                begin
                    len = 0;
                    en = 16'h0000;
                    lim = '0;
                end
                1:
                begin
                    len = 31;
                    en = 16'hFFFF;
                    lim = {mbps_pkg::LIMIT_BITS{1'b1}};
                end
                2:
                begin
                    len = mbps_pkg::PATTERN_BYTES;
                    en = 16'($urandom);
                    lim = 23'd1;
                end
                default:
                begin
                    len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 16)
                                                       : $urandom_range(0, 31);
                    case ($urandom_range(0, 3))
                        0:       en = 16'hFFFF;
                        1:       en = 16'($urandom) | 16'($urandom);
                        2:       en = 16'($urandom) & 16'($urandom);
                        default: en = 16'($urandom);
                    endcase
                    lim = ($urandom_range(0, 99) < 60)
                          ? mbps_pkg::LIMIT_BITS'($urandom_range(1, 12))
                          : mbps_pkg::LIMIT_BITS'($urandom);
                end
            endcase
            no_idle = (phase == 3);
            write_reg(mbps_pkg::REG_PATTERN_LOW, random64());
            write_reg(mbps_pkg::REG_PATTERN_HIGH, random64());
            value = random64();
            value[15:0] = en;
            write_reg(mbps_pkg::REG_COMPARE_EN, value);
            value = random64();
            value[mbps_pkg::PLEN_BITS-1:0] = mbps_pkg::PLEN_BITS'(len);
            write_reg(mbps_pkg::REG_PATTERN_LEN, value);
            value = random64();
            value[mbps_pkg::LIMIT_BITS-1:0] = lim;
            write_reg(mbps_pkg::REG_MATCH_LIMIT, value);

            // byte stream
            plant_idx = mbps_pkg::PATTERN_BYTES;
            a = {16'($urandom_range(0, 65535)), 32'($urandom)};
            for (n = 0; n < PHASE_BYTES; n++)
            begin
                r = $urandom_range(0, 99);
                rs = 1'b0;
                ss = (n == 0) && r[0];
                if (plant_idx >= active_length() && r < 35)
                    plant_idx = 0;
                if (plant_idx < active_length())
                begin
                    d = (cmp_enable[plant_idx] && $urandom_range(0, 49) != 0)
                        ? pattern_byte(plant_idx) : 8'($urandom);
                    plant_idx++;
                end
                else
                    d = (r < 55) ? pattern_byte($urandom_range(0, 15)) : 8'($urandom);
                a = a + mbps_pkg::OUT_ADDR_BITS'(1);
                r2 = $urandom_range(0, 199);
                if (r2 < 4)
                begin
                    rs = 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        a = {mbps_pkg::OUT_ADDR_BITS{1'b1}}
                            - mbps_pkg::OUT_ADDR_BITS'($urandom_range(0, 40));
                    else
                        a = {16'($urandom_range(0, 65535)), 32'($urandom)};
                end
                else if (r2 < 6)
                    rs = 1'b1;
                else if (r2 < 9)
                    ss = 1'b1;
                else if (r2 == 9)
                begin
                    ss = 1'b1;
                    rs = 1'b1;
                end
                send_byte(d, a, rs, ss);
            end
            drain_matches();
        end
        no_idle = 1'b0;
    endtask

    // result side backpressure
    always @(posedge clk)
    begin
        if (no_idle)
            out_ready <= 1'b1;
        else if (ready_hold > 0)
            ready_hold = ready_hold - 1;
        else if (out_ready)
        begin
            ready_gap = pick_gap();
            if (ready_gap > 0)
            begin
                out_ready <= 1'b0;
                ready_hold = ready_gap - 1;
            end
            else
                ready_hold = $urandom_range(0, 8);
        end
        else
        begin
            out_ready <= 1'b1;
            ready_hold = $urandom_range(0, 15);
        end
    end

    // compare each result beat with the oldest expected match
    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && out_ready)
        begin
            if (expected_matches.size() == 0)
            begin
                $display("%0t unexpected result beat: expected none actual %h %h %b",
                         $time, match_address, first_byte, limit_reached);
                error_count++;
            end
            else
            begin
                oldest_match = expected_matches.pop_front();
                if (match_address !== oldest_match.addr)
                begin
                    $display("%0t match_address: expected %h actual %h",
                             $time, oldest_match.addr, match_address);
                    error_count++;
                end
                if (first_byte !== oldest_match.first)
                begin
                    $display("%0t first_byte: expected %h actual %h",
                             $time, oldest_match.first, first_byte);
                    error_count++;
                end
                if (limit_reached !== oldest_match.limit)
                begin
                    $display("%0t limit_reached: expected %b actual %b",
                             $time, oldest_match.limit, limit_reached);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("%0t watchdog: no beat accepted for %0d cycles", $time, idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_masked_window();
        test_run_split();
        test_match_limit();
        test_random_stream();
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
